// ===== sv/ncc_pkg.sv =====
// ----------------------------------------------------------------------------
// ncc_pkg: shared types and constants
// Transfer structs, controller commands and arithmetic widths for the
// normalized cross-correlation block.
// ----------------------------------------------------------------------------
package ncc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ENERGY_W = 51;
    localparam int CROSS_W  = 52;
    localparam int HALF_W   = 26;
    localparam int PROD_W   = 102;
    localparam int MSQ_W    = 104;
    localparam int KP_W     = 120;
    localparam int RES_W    = 138;
    localparam int CORR_W   = 16;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
    localparam logic [3:0] MUL_LAST = 4'd8;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] map_sample;
        logic signed [SAMPLE_W-1:0] model_sample;
        logic                       last;
    } in_t;

    typedef struct packed {
        logic signed [CORR_W-1:0] correlation;
        logic [ENERGY_W-1:0]      map_energy;
        logic [ENERGY_W-1:0]      model_energy;
        logic                     degenerate;
    } out_t;

    typedef struct packed {
        logic       mul_issue;
        logic [2:0] mul_sel;
        logic       search_init;
        logic       term_calc;
        logic       trial;
        logic [3:0] bit_sel;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic set_closed;
    } status_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DRAIN = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_INIT  = 7'b0001000,
        ST_TERM  = 7'b0010000,
        ST_TRIAL = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

endpackage

// ===== sv/normalized_cross_correlation.sv =====
// ----------------------------------------------------------------------------
// normalized_cross_correlation: uncentred normalized cross-correlation
// Accumulates sample pairs and reports correlation and both energies per set.
// ----------------------------------------------------------------------------
// Pairs are taken one per cycle while busy is low.
// After the transfer that carries last, busy stays high while the controller
// closes the sums, steps the shared 26x26 multiplier, sets up and runs the
// shift-and-subtract search with a term step and a trial step per result bit,
// then registers the result. Busy falls as the result strobe rises.
// Reset clears the sums and the controller; the receiver cannot stall.
module normalized_cross_correlation (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  ncc_pkg::in_t  item,
    output logic          valid,
    output ncc_pkg::out_t result
);

    ncc_pkg::cmd_t    cmd;
    ncc_pkg::status_t status;
    logic             take;

    assign take = start && !busy;

    ncc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (take),
        .last   (item.last),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    ncc_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .valid  (valid),
        .result (result)
    );

endmodule

// ===== sv/ncc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ncc_ctrl: sequencing controller
// Closes a data set, steps the shared multiplier and the bitwise search.
// ----------------------------------------------------------------------------
module ncc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             last,
    input  ncc_pkg::status_t status,
    output logic             busy,
    output ncc_pkg::cmd_t    cmd
);

    ncc_pkg::state_t state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ncc_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cmd             = '0;
        cmd.mul_sel     = cnt_reg[2:0];
        cmd.bit_sel     = cnt_reg;
        unique case (state_reg)
            ncc_pkg::ST_IDLE:
            begin
                if (start && last)
                begin
                    state_next = ncc_pkg::ST_DRAIN;
                end
            end
            ncc_pkg::ST_DRAIN:
            begin
                if (status.set_closed)
                begin
                    state_next = ncc_pkg::ST_MUL;
                    cnt_next   = '0;
                end
            end
            ncc_pkg::ST_MUL:
            begin
                // The last count only lets the final partial product settle.
                cmd.mul_issue = (cnt_reg != ncc_pkg::MUL_LAST);
                cnt_next      = cnt_reg + 4'd1;
                if (cnt_reg == ncc_pkg::MUL_LAST)
                begin
                    state_next = ncc_pkg::ST_INIT;
                end
            end
            ncc_pkg::ST_INIT:
            begin
                cmd.search_init = 1'b1;
                cnt_next        = 4'd15;
                state_next      = ncc_pkg::ST_TERM;
            end
            ncc_pkg::ST_TERM:
            begin
                cmd.term_calc = 1'b1;
                state_next    = ncc_pkg::ST_TRIAL;
            end
            ncc_pkg::ST_TRIAL:
            begin
                cmd.trial = 1'b1;
                cnt_next  = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    state_next = ncc_pkg::ST_FIN;
                end
                else
                begin
                    state_next = ncc_pkg::ST_TERM;
                end
            end
            ncc_pkg::ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ncc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ncc_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ncc_pkg::ST_IDLE);

endmodule

// ===== sv/ncc_dp.sv =====
// ----------------------------------------------------------------------------
// ncc_dp: datapath
// Product pipeline and saturating sums, a shared 26x26 multiplier and the
// shift-and-subtract search for the rounded correlation magnitude.
// ----------------------------------------------------------------------------
module ncc_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  ncc_pkg::in_t     item,
    input  ncc_pkg::cmd_t    cmd,
    output ncc_pkg::status_t status,
    output logic             valid,
    output ncc_pkg::out_t    result
);

    localparam int SW = ncc_pkg::SAMPLE_W;
    localparam int EW = ncc_pkg::ENERGY_W;
    localparam int CW = ncc_pkg::CROSS_W;
    localparam int HW = ncc_pkg::HALF_W;
    localparam int PW = ncc_pkg::PROD_W;
    localparam int MW = ncc_pkg::MSQ_W;
    localparam int KW = ncc_pkg::KP_W;
    localparam int RW = ncc_pkg::RES_W;
    localparam int CORR_BITS = ncc_pkg::CORR_W;

    // Product stage
    logic                  s1_vld_reg, s1_last_reg;
    logic signed [2*SW-1:0] x_reg;
    logic [2*SW-2:0]        sa_reg, sb_reg;

    // Running sums and the snapshot of a closed set
    logic signed [CW-1:0] cross_reg, c_snap_reg;
    logic [EW-1:0]        e1_reg, e2_reg, e1_snap_reg, e2_snap_reg;

    // Shared multiplier
    logic [2*HW-1:0] pp_reg;
    logic            pp_vld_reg;
    logic [2:0]      pp_sel_reg;
    logic [PW-1:0]   p_reg;
    logic [MW-1:0]   m2_reg;

    // Search
    logic signed [RW-1:0] r_reg, term_reg;
    logic signed [KW-1:0] kp_reg;
    logic [CORR_BITS-1:0] q_reg;

    logic                 valid_reg;
    ncc_pkg::out_t        result_reg;

    logic signed [CW:0]   cross_sum;
    logic [EW:0]          e1_sum, e2_sum;
    logic signed [CW-1:0] cross_sat;
    logic [EW-1:0]        e1_sat, e2_sat;

    logic [CW-1:0]        m_abs;
    logic [HW-1:0]        op_a, op_b;
    logic [6:0]           pp_shift;
    logic [PW+CW:0]       pp_wide;

    logic signed [RW-1:0] p_ext, diff;
    logic [4:0]           b1;
    logic                 accept_bit;
    logic                 neg;
    logic [CORR_BITS-1:0] mag;

    assign cross_sum = {cross_reg[CW-1], cross_reg} + (CW+1)'(x_reg);
    assign e1_sum    = {1'b0, e1_reg} + (EW+1)'(sa_reg);
    assign e2_sum    = {1'b0, e2_reg} + (EW+1)'(sb_reg);

    always_comb
    begin
        if (cross_sum[CW] != cross_sum[CW-1])
        begin
            cross_sat = cross_sum[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        else
        begin
            cross_sat = cross_sum[CW-1:0];
        end
        e1_sat = e1_sum[EW] ? ncc_pkg::ENERGY_MAX : e1_sum[EW-1:0];
        e2_sat = e2_sum[EW] ? ncc_pkg::ENERGY_MAX : e2_sum[EW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s1_last_reg <= 1'b0;
            cross_reg   <= '0;
            e1_reg      <= '0;
            e2_reg      <= '0;
            pp_vld_reg  <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= take;
            s1_last_reg <= take && item.last;
            if (s1_vld_reg)
            begin
                if (s1_last_reg)
                begin
                    cross_reg <= '0;
                    e1_reg    <= '0;
                    e2_reg    <= '0;
                end
                else
                begin
                    cross_reg <= cross_sat;
                    e1_reg    <= e1_sat;
                    e2_reg    <= e2_sat;
                end
            end
            pp_vld_reg <= cmd.mul_issue;
            valid_reg  <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg  <= item.map_sample * item.model_sample;
        sa_reg <= (2*SW-1)'((2*SW)'(item.map_sample) * (2*SW)'(item.map_sample));
        sb_reg <= (2*SW-1)'((2*SW)'(item.model_sample) * (2*SW)'(item.model_sample));
        if (s1_vld_reg && s1_last_reg)
        begin
            c_snap_reg  <= cross_sat;
            e1_snap_reg <= e1_sat;
            e2_snap_reg <= e2_sat;
        end
    end

    assign status.set_closed = s1_vld_reg && s1_last_reg;

    // Energy product and squared cross magnitude, from four partial products each.
    assign m_abs = c_snap_reg[CW-1] ? CW'(-c_snap_reg) : CW'(c_snap_reg);

    always_comb
    begin
        if (cmd.mul_sel[2])
        begin
            op_a = cmd.mul_sel[1] ? m_abs[2*HW-1:HW] : m_abs[HW-1:0];
            op_b = cmd.mul_sel[0] ? m_abs[2*HW-1:HW] : m_abs[HW-1:0];
        end
        else
        begin
            op_a = cmd.mul_sel[1] ? HW'(e1_snap_reg[EW-1:HW]) : e1_snap_reg[HW-1:0];
            op_b = cmd.mul_sel[0] ? HW'(e2_snap_reg[EW-1:HW]) : e2_snap_reg[HW-1:0];
        end
        pp_shift = 7'(HW) * 7'({1'b0, pp_sel_reg[1]} + {1'b0, pp_sel_reg[0]});
        pp_wide  = (PW+CW+1)'(pp_reg) << pp_shift;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_issue)
        begin
            pp_reg     <= op_a * op_b;
            pp_sel_reg <= cmd.mul_sel;
        end
        if (status.set_closed)
        begin
            p_reg  <= '0;
            m2_reg <= '0;
        end
        else if (pp_vld_reg)
        begin
            if (pp_sel_reg[2])
            begin
                m2_reg <= m2_reg + MW'(pp_wide);
            end
            else
            begin
                p_reg <= p_reg + PW'(pp_wide);
            end
        end
    end

    // Search state: r = 2^32*m^2 - k^2*P and kp = k*P with k = 2q - 1.
    assign p_ext      = RW'(p_reg);
    assign b1         = {1'b0, cmd.bit_sel} + 5'd1;
    assign diff       = r_reg - term_reg;
    assign accept_bit = !diff[RW-1] && !q_reg[CORR_BITS-1];

    always_ff @(posedge clk)
    begin
        if (cmd.search_init)
        begin
            r_reg  <= (RW'(m2_reg) <<< 32) - p_ext;
            kp_reg <= -KW'(p_reg);
            q_reg  <= '0;
        end
        if (cmd.term_calc)
        begin
            term_reg <= (RW'(kp_reg) <<< (b1 + 5'd1)) + (p_ext <<< {b1, 1'b0});
        end
        if (cmd.trial && accept_bit)
        begin
            r_reg  <= diff;
            kp_reg <= kp_reg + (KW'(p_reg) <<< b1);
            q_reg  <= q_reg | (CORR_BITS'(1) << cmd.bit_sel);
        end
    end

    assign neg = c_snap_reg[CW-1];
    assign mag = (!neg && q_reg[CORR_BITS-1]) ? {1'b0, {(CORR_BITS-1){1'b1}}} : q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_reg.map_energy   <= e1_snap_reg;
            result_reg.model_energy <= e2_snap_reg;
            if (e1_snap_reg == '0 || e2_snap_reg == '0)
            begin
                result_reg.degenerate  <= 1'b1;
                result_reg.correlation <= '0;
            end
            else
            begin
                result_reg.degenerate  <= 1'b0;
                result_reg.correlation <= neg ? -$signed(mag) : $signed(mag);
            end
        end
    end

    assign valid  = valid_reg;
    assign result = result_reg;

endmodule

// ===== sv/ncc_check.sv =====
// ----------------------------------------------------------------------------
// ncc_check: port-level checks
// Observes the top-level ports over time and reports violations.
// ----------------------------------------------------------------------------
module ncc_check (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input ncc_pkg::in_t  item,
    input logic          valid,
    input ncc_pkg::out_t result
);

    // A set closes with a long busy period, so strobes never abut.
    assert property (@(posedge clk) disable iff (!rst_n) valid |-> !$past(valid))
        else $error("result strobe held for more than one cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.last |=> busy)
        else $error("busy did not rise after the closing transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid && result.degenerate |-> result.correlation == '0)
        else $error("degenerate result with non-zero correlation");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !result.degenerate |-> result.map_energy != '0 && result.model_energy != '0)
        else $error("zero energy not flagged as degenerate");

endmodule

bind normalized_cross_correlation ncc_check u_ncc_check (.*);

// ===== tb/sv/tb_normalized_cross_correlation.sv =====
// ----------------------------------------------------------------------------
// tb_normalized_cross_correlation: self-checking bench for the correlator
// Streams sample pairs in sets, predicts each set's correlation and energies
// with exact integer arithmetic, and compares every result transfer.
// ----------------------------------------------------------------------------
module tb_normalized_cross_correlation;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    ncc_pkg::in_t   item = '0;
    logic           valid;
    ncc_pkg::out_t  result;

    // Running sums of the set currently being streamed.
    logic signed [ncc_pkg::CROSS_W-1:0] pred_cross;
    logic [ncc_pkg::ENERGY_W-1:0]       pred_map_e;
    logic [ncc_pkg::ENERGY_W-1:0]       pred_model_e;
    ncc_pkg::out_t                      expected_results[$];
    int                                 mismatches = 0;
    int                                 idle_cycles = 0;
    bit                                 gaps_on = 1'b1;

    normalized_cross_correlation uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .valid  (valid),
        .result (result)
    );

    always #5 clk = ~clk;

    // Rounded magnitude of 2^15*m/sqrt(e1*e2), capped at 32768. The result q is the
    // largest value with e1*e2*(2q-1)^2 <= m^2 * 2^32.
    function automatic logic [16:0] corr_magnitude(logic [51:0] m, logic [50:0] e1,
                                                   logic [50:0] e2);
        logic [191:0] lhs;
        logic [191:0] rhs;
        logic [191:0] k;
        logic [16:0]  lo;
        logic [16:0]  hi;
        logic [16:0]  q;
        lo = 0;
        hi = 17'd32768;
        rhs = ({140'd0, m} * {140'd0, m}) << 32;
        while (lo < hi)
        begin
            q = lo + (hi - lo + 1) / 2;
            k = 2 * q - 1;
            lhs = {141'd0, e1} * {141'd0, e2} * (k * k);
            if (lhs <= rhs)
                lo = q;
            else
                hi = q - 1;
        end
        return lo;
    endfunction

    function automatic void accumulate_pair(ncc_pkg::in_t it);
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] c;
        logic [63:0]        e;
        logic [63:0]        mag;
        logic signed [63:0] corr;
        ncc_pkg::out_t      r;
        a = it.map_sample;
        b = it.model_sample;
        c = 64'(pred_cross) + a * b;
        if (c > 64'sd2251799813685247)
            c = 64'sd2251799813685247;
        if (c < -64'sd2251799813685248)
            c = -64'sd2251799813685248;
        pred_cross = c[ncc_pkg::CROSS_W-1:0];
        e = {13'd0, pred_map_e} + 64'(a * a);
        pred_map_e = (e > {13'd0, ncc_pkg::ENERGY_MAX}) ? ncc_pkg::ENERGY_MAX
                                                       : e[ncc_pkg::ENERGY_W-1:0];
        e = {13'd0, pred_model_e} + 64'(b * b);
        pred_model_e = (e > {13'd0, ncc_pkg::ENERGY_MAX}) ? ncc_pkg::ENERGY_MAX
                                                         : e[ncc_pkg::ENERGY_W-1:0];
        if (it.last)
        begin
            r = '0;
            r.map_energy = pred_map_e;
            r.model_energy = pred_model_e;
            if (pred_map_e == 0 || pred_model_e == 0)
                r.degenerate = 1'b1;
            else
            begin
                mag = (c < 0) ? 64'(-c) : 64'(c);
                corr = 64'(corr_magnitude(mag[51:0], pred_map_e, pred_model_e));
                if (c < 0)
                    corr = -corr;
                if (corr > 32767)
                    corr = 32767;
                r.correlation = corr[15:0];
            end
            expected_results = {expected_results, r};
            pred_cross = '0;
            pred_map_e = '0;
            pred_model_e = '0;
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        mismatches++;
    endtask

    // Sends one pair; start stays high only while pairs follow back to back.
    task automatic send_pair(logic signed [15:0] ms, logic signed [15:0] md, logic lst);
        ncc_pkg::in_t it;
        logic         was_busy;
        it.map_sample = ms;
        it.model_sample = md;
        it.last = lst;
        while (gaps_on && $urandom_range(99) < 9)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        // Busy is sampled mid-cycle, so it is the value seen at the next edge.
        do
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
        end
        while (was_busy);
        accumulate_pair(it);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return -16'sh8000;
            2: return 16'($signed($urandom_range(16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        ncc_pkg::out_t want;
        if (valid)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result transfer", 64'd0, 64'd0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.correlation !== want.correlation)
                    report_mismatch("correlation", 64'(result.correlation),
                                    64'(want.correlation));
                if (result.map_energy !== want.map_energy)
                    report_mismatch("map_energy", 64'(result.map_energy),
                                    64'(want.map_energy));
                if (result.model_energy !== want.model_energy)
                    report_mismatch("model_energy", 64'(result.model_energy),
                                    64'(want.model_energy));
                if (result.degenerate !== want.degenerate)
                    report_mismatch("degenerate", 64'(result.degenerate),
                                    64'(want.degenerate));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_extremes();
        send_pair(16'sh7fff, 16'sh7fff, 1'b1);
        send_pair(-16'sh8000, -16'sh8000, 1'b1);
        send_pair(16'sh7fff, -16'sh8000, 1'b1);
        send_pair(-16'sh8000, 16'sh7fff, 1'b1);
        send_pair(16'sh0001, -16'sh0001, 1'b1);
        send_pair(16'sh0003, 16'sh0004, 1'b0);
        send_pair(16'sh0004, -16'sh0003, 1'b1);
    endtask

    task automatic test_degenerate();
        send_pair(16'sh0000, 16'sh0000, 1'b1);
        send_pair(16'sh0000, 16'sh1234, 1'b1);
        send_pair(-16'sh5555, 16'sh0000, 1'b0);
        send_pair(16'sh0000, 16'sh0000, 1'b1);
    endtask

    task automatic test_partial_correlation();
        send_pair(16'sh1000, 16'sh1000, 1'b0);
        send_pair(16'sh1000, -16'sh1000, 1'b0);
        send_pair(16'sh0800, 16'sh0400, 1'b1);
        send_pair(16'sh0003, 16'sh0001, 1'b0);
        send_pair(16'sh0001, 16'sh0003, 1'b1);
    endtask

    task automatic test_random_sets(int pairs);
        int sent;
        int len;
        int scale;
        logic signed [15:0] ms;
        sent = 0;
        while (sent < pairs)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
            scale = $urandom_range(3);
            for (int i = 0; i < len; i++)
            begin
                ms = rand_sample();
                // Correlated sets push the result towards the saturated ends.
                case (scale)
                    0: send_pair(ms, ms, i == len - 1);
                    1: send_pair(ms, -ms, i == len - 1);
                    default: send_pair(ms, rand_sample(), i == len - 1);
                endcase
                sent++;
            end
        end
    endtask

    initial
    begin
        pred_cross = '0;
        pred_map_e = '0;
        pred_model_e = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_degenerate();
        test_partial_correlation();
        test_random_sets(350);
        gaps_on = 1'b0;
        test_random_sets(150);
        gaps_on = 1'b1;
        test_random_sets(180);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== files.f =====
sv/ncc_pkg.sv
sv/ncc_ctrl.sv
sv/ncc_dp.sv
sv/normalized_cross_correlation.sv
sv/ncc_check.sv
tb/sv/tb_normalized_cross_correlation.sv
